>>> sv/lnh_pkg.sv
// ----------------------------------------------------------------------------
// lnh_pkg
// Shared types, constants and the byte classifier of the letter n-gram
// histogram unit.
// ----------------------------------------------------------------------------
package lnh_pkg;

    localparam int BYTE_BITS      = 8;
    localparam int SYM_BITS       = 5;
    localparam int LEN_BITS       = 2;
    localparam int KEY_BITS       = 15;
    localparam int OUT_COUNT_BITS = 32;
    localparam int OUT_TOTAL_BITS = 48;
    localparam int WIDE_BITS      = 64;

    // Table address widths, one symbol slot per gram position
    localparam int ADDR_ONE   = SYM_BITS;
    localparam int ADDR_TWO   = 2 * SYM_BITS;
    localparam int ADDR_THREE = 3 * SYM_BITS;

    localparam logic [SYM_BITS-1:0]  SEP_SYMBOL = 5'd26;
    localparam logic [1:0]           FILL_MAX   = 2'd3;
    localparam logic [1:0]           FILL_ONE   = 2'd1;
    localparam logic [1:0]           FILL_TWO   = 2'd2;

    localparam logic [BYTE_BITS-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [BYTE_BITS-1:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [BYTE_BITS-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [BYTE_BITS-1:0] CHAR_LOWER_Z = 8'h7A;

    localparam logic MODE_FEED = 1'b0;
    localparam logic MODE_READ = 1'b1;

    localparam logic [LEN_BITS-1:0] LEN_ONE   = 2'd1;
    localparam logic [LEN_BITS-1:0] LEN_TWO   = 2'd2;
    localparam logic [LEN_BITS-1:0] LEN_THREE = 2'd3;

    typedef struct packed {
        logic                vld;
        logic                inc;
        logic [KEY_BITS-1:0] key;
    } t_tbl_req;

    typedef struct packed {
        logic                en;
        logic [KEY_BITS-1:0] idx;
    } t_clr;

    typedef struct packed {
        logic                vld;
        logic                sep;
        logic [SYM_BITS-1:0] code;
    } t_sym;

    typedef struct packed {
        logic                      sym_vld;
        logic [SYM_BITS-1:0]       sym_code;
        logic [OUT_COUNT_BITS-1:0] gram_count;
        logic [OUT_TOTAL_BITS-1:0] char_total;
        logic [OUT_TOTAL_BITS-1:0] word_total;
    } t_result;

    // Fold letters to 0..25; first non-letter of a run becomes the separator
    function automatic t_sym classify(input logic [BYTE_BITS-1:0] b, input logic last_sep);
        t_sym s;
        s = '0;
        if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) begin
            s.vld  = 1'b1;
            s.code = SYM_BITS'(b - CHAR_UPPER_A);
        end else if (b >= CHAR_LOWER_A && b <= CHAR_LOWER_Z) begin
            s.vld  = 1'b1;
            s.code = SYM_BITS'(b - CHAR_LOWER_A);
        end else if (!last_sep) begin
            s.vld  = 1'b1;
            s.sep  = 1'b1;
            s.code = SEP_SYMBOL;
        end
        return s;
    endfunction

endpackage

>>> sv/lnh_front.sv
// ----------------------------------------------------------------------------
// lnh_front
// Byte classification, symbol history, fill position and running totals;
// issues the table requests of each accepted read and of each symbol fed.
// ----------------------------------------------------------------------------
module lnh_front #(
    parameter int MAX_GRAM   = 3,
    parameter int TOTAL_BITS = 48
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic                          i_mode,
    input  logic                          i_start,
    input  logic [lnh_pkg::BYTE_BITS-1:0] i_byte,
    input  logic [lnh_pkg::KEY_BITS-1:0]  i_read_key,
    output lnh_pkg::t_sym                 o_sym,
    output lnh_pkg::t_tbl_req             o_req_one,
    output lnh_pkg::t_tbl_req             o_req_two,
    output lnh_pkg::t_tbl_req             o_req_three,
    output logic [TOTAL_BITS-1:0]         o_chars,
    output logic [TOTAL_BITS-1:0]         o_words
);
    import lnh_pkg::*;

    localparam int GRAM_LIM = (MAX_GRAM > 3) ? 3 : MAX_GRAM;

    logic [KEY_BITS-1:0]   r_hist, n_hist;
    logic [1:0]            r_fill, n_fill;
    logic                  r_last_sep, n_last_sep;
    logic [TOTAL_BITS-1:0] r_chars, n_chars;
    logic [TOTAL_BITS-1:0] r_words, n_words;

    logic [KEY_BITS-1:0] hist0;
    logic [1:0]          fill0;
    logic                sep0;
    logic                feed;
    logic                rd;
    t_sym                sym;

    always_comb begin
        hist0 = i_start ? '0 : r_hist;
        fill0 = i_start ? '0 : r_fill;
        sep0  = i_start ? 1'b0 : r_last_sep;
        sym   = classify(i_byte, sep0);
        feed  = i_accept && (i_mode == MODE_FEED);
        rd    = i_accept && (i_mode == MODE_READ);

        n_hist     = r_hist;
        n_fill     = r_fill;
        n_last_sep = r_last_sep;
        n_chars    = r_chars;
        n_words    = r_words;
        o_req_one   = '0;
        o_req_two   = '0;
        o_req_three = '0;

        if (feed) begin
            n_hist     = hist0;
            n_fill     = fill0;
            n_last_sep = sym.vld ? sym.sep : sep0;
            if (sym.vld) begin
                n_hist  = {hist0[KEY_BITS-SYM_BITS-1:0], sym.code};
                n_chars = (r_chars == '1) ? r_chars : r_chars + TOTAL_BITS'(1);
                if (sym.sep) begin
                    n_words = (r_words == '1) ? r_words : r_words + TOTAL_BITS'(1);
                end
                if (fill0 != FILL_MAX) begin
                    n_fill = fill0 + FILL_ONE;
                end
                o_req_one.inc   = (GRAM_LIM >= 1);
                o_req_two.inc   = (GRAM_LIM >= 2) && (fill0 >= FILL_ONE);
                o_req_three.inc = (GRAM_LIM >= 3) && (fill0 >= FILL_TWO);
                o_req_one.vld   = o_req_one.inc;
                o_req_two.vld   = o_req_two.inc;
                o_req_three.vld = o_req_three.inc;
                o_req_one.key   = n_hist;
                o_req_two.key   = n_hist;
                o_req_three.key = n_hist;
            end
        end else if (rd) begin
            o_req_one   = '{vld: 1'b1, inc: 1'b0, key: i_read_key};
            o_req_two   = '{vld: 1'b1, inc: 1'b0, key: i_read_key};
            o_req_three = '{vld: 1'b1, inc: 1'b0, key: i_read_key};
        end

        o_sym   = feed ? sym : '0;
        o_chars = n_chars;
        o_words = n_words;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist     <= '0;
            r_fill     <= '0;
            r_last_sep <= 1'b0;
            r_chars    <= '0;
            r_words    <= '0;
        end else begin
            r_hist     <= n_hist;
            r_fill     <= n_fill;
            r_last_sep <= n_last_sep;
            r_chars    <= n_chars;
            r_words    <= n_words;
        end
    end

endmodule

>>> sv/lnh_count_table.sv
// ----------------------------------------------------------------------------
// lnh_count_table
// One histogram table: synchronous memory with saturating read-modify-write,
// one-deep write bypass and a clearing write port.
// ----------------------------------------------------------------------------
module lnh_count_table #(
    parameter int ADDR_BITS  = 5,
    parameter int COUNT_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  lnh_pkg::t_clr         i_clr,
    input  lnh_pkg::t_tbl_req     i_req,
    output logic [COUNT_BITS-1:0] o_value
);
    import lnh_pkg::*;

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [COUNT_BITS-1:0] r_mem [DEPTH];
    logic [COUNT_BITS-1:0] r_rdata;
    logic [ADDR_BITS-1:0]  r_addr;
    logic                  r_inc;
    logic                  r_vld;
    logic                  r_byp_vld;
    logic [ADDR_BITS-1:0]  r_byp_addr;
    logic [COUNT_BITS-1:0] r_byp_data;

    logic [COUNT_BITS-1:0] cur;
    logic [COUNT_BITS-1:0] inc_val;
    logic                  item_wr;
    logic                  wr_en;
    logic [ADDR_BITS-1:0]  wr_addr;
    logic [COUNT_BITS-1:0] wr_data;

    always_comb begin
        // Take the write that landed on the same edge as our read
        cur     = (r_byp_vld && (r_byp_addr == r_addr)) ? r_byp_data : r_rdata;
        inc_val = (cur == '1) ? cur : cur + COUNT_BITS'(1);
        item_wr = r_vld && r_inc;
        wr_en   = i_clr.en || item_wr;
        wr_addr = i_clr.en ? i_clr.idx[ADDR_BITS-1:0] : r_addr;
        wr_data = i_clr.en ? '0 : inc_val;
    end

    assign o_value = cur;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_req.vld) begin
            r_rdata <= r_mem[i_req.key[ADDR_BITS-1:0]];
            r_addr  <= i_req.key[ADDR_BITS-1:0];
            r_inc   <= i_req.inc;
        end
        r_byp_addr <= wr_addr;
        r_byp_data <= wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= 1'b0;
            r_byp_vld <= 1'b0;
        end else begin
            r_vld     <= i_req.vld;
            r_byp_vld <= item_wr && !i_clr.en;
        end
    end

`ifndef SYNTHESIS
    a_no_req_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_clr.en |-> !i_req.vld)
        else $error("table request during clearing pass");
    a_no_item_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_clr.en |-> !r_vld)
        else $error("clear write collides with a pending increment");
    a_bypass_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (item_wr && !i_clr.en) |=> (r_byp_vld && r_byp_data == $past(inc_val)))
        else $error("bypass does not hold the last increment");
`endif

endmodule

>>> sv/letter_ngram_histogram_unit.sv
// ----------------------------------------------------------------------------
// letter_ngram_histogram_unit
// Letter n-gram histogram of a byte stream, with count read-back.
// ----------------------------------------------------------------------------
// Takes one transaction per clock cycle once the clearing pass is done and the
// output queue has room. After reset the three count tables are swept to zero,
// one entry per cycle across the 32768 entries of the three-symbol table, and
// o_in_ready stays low throughout. A transaction is classified and its table
// reads issued on the accepting edge; on the next edge each table adds one to
// the forwarded count and writes it back, so back-to-back grams that hit the
// same entry are always counted exactly. On that same edge the result enters
// a three-entry output queue and is offered on the output channel from then
// on. The rate is set by the single read-modify-write slot of each table
// memory: one per cycle while the output queue has room.
// Read transactions return the count of the gram given by the key and length;
// feed transactions return the symbol produced and the running totals.
// ----------------------------------------------------------------------------
module letter_ngram_histogram_unit #(
    parameter int MAX_GRAM   = 3,
    parameter int COUNT_BITS = 32,
    parameter int TOTAL_BITS = 48
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input channel
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_mode,
    input  logic                               i_start_of_text,
    input  logic [lnh_pkg::BYTE_BITS-1:0]      i_text_byte,
    input  logic [lnh_pkg::LEN_BITS-1:0]       i_read_length,
    input  logic [lnh_pkg::KEY_BITS-1:0]       i_read_key,
    // output channel
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic                               o_symbol_valid,
    output logic [lnh_pkg::SYM_BITS-1:0]       o_symbol_code,
    output logic [lnh_pkg::OUT_COUNT_BITS-1:0] o_gram_count,
    output logic [lnh_pkg::OUT_TOTAL_BITS-1:0] o_char_total,
    output logic [lnh_pkg::OUT_TOTAL_BITS-1:0] o_word_total
);
    import lnh_pkg::*;

    localparam int QUEUE_DEPTH = 3;
    localparam logic [1:0] LAST_SLOT = 2'(QUEUE_DEPTH - 1);

    // Clearing pass
    t_clr r_clr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr.en  <= 1'b1;
            r_clr.idx <= '0;
        end else if (r_clr.en) begin
            r_clr.idx <= r_clr.idx + KEY_BITS'(1);
            if (r_clr.idx == '1) begin
                r_clr.en <= 1'b0;
            end
        end
    end

    // Front end: classify, keep history and totals, issue table requests
    logic                  in_accept;
    t_sym                  front_sym;
    t_tbl_req              req_one, req_two, req_three;
    logic [TOTAL_BITS-1:0] front_chars, front_words;
    logic [WIDE_BITS-1:0]  chars_wide, words_wide;

    assign in_accept = i_in_valid && o_in_ready;

    lnh_front #(
        .MAX_GRAM   (MAX_GRAM),
        .TOTAL_BITS (TOTAL_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_mode      (i_mode),
        .i_start     (i_start_of_text),
        .i_byte      (i_text_byte),
        .i_read_key  (i_read_key),
        .o_sym       (front_sym),
        .o_req_one   (req_one),
        .o_req_two   (req_two),
        .o_req_three (req_three),
        .o_chars     (front_chars),
        .o_words     (front_words)
    );

    assign chars_wide = WIDE_BITS'(front_chars);
    assign words_wide = WIDE_BITS'(front_words);

    // Count tables, one per gram length
    logic [COUNT_BITS-1:0] val_one, val_two, val_three;

    lnh_count_table #(.ADDR_BITS(ADDR_ONE), .COUNT_BITS(COUNT_BITS)) u_tbl_one (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_clr (r_clr), .i_req (req_one),
        .o_value (val_one)
    );

    lnh_count_table #(.ADDR_BITS(ADDR_TWO), .COUNT_BITS(COUNT_BITS)) u_tbl_two (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_clr (r_clr), .i_req (req_two),
        .o_value (val_two)
    );

    lnh_count_table #(.ADDR_BITS(ADDR_THREE), .COUNT_BITS(COUNT_BITS)) u_tbl_three (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_clr (r_clr), .i_req (req_three),
        .o_value (val_three)
    );

    // Second stage: hold the transaction while the tables update
    logic                      r_s1_vld;
    logic                      r_s1_mode;
    logic [LEN_BITS-1:0]       r_s1_len;
    t_sym                      r_s1_sym;
    logic [OUT_TOTAL_BITS-1:0] r_s1_chars;
    logic [OUT_TOTAL_BITS-1:0] r_s1_words;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= in_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_mode  <= i_mode;
            r_s1_len   <= i_read_length;
            r_s1_sym   <= front_sym;
            r_s1_chars <= chars_wide[OUT_TOTAL_BITS-1:0];
            r_s1_words <= words_wide[OUT_TOTAL_BITS-1:0];
        end
    end

    // Select the read-back count; length zero reads nothing
    logic [COUNT_BITS-1:0] sel_count;
    logic [WIDE_BITS-1:0]  count_wide;
    t_result               s1_result;

    always_comb begin
        sel_count = '0;
        if (r_s1_mode == MODE_READ) begin
            unique case (r_s1_len)
                LEN_ONE:   sel_count = val_one;
                LEN_TWO:   sel_count = val_two;
                LEN_THREE: sel_count = val_three;
                default:   sel_count = '0;
            endcase
        end
        count_wide           = WIDE_BITS'(sel_count);
        s1_result.sym_vld    = r_s1_sym.vld;
        s1_result.sym_code   = r_s1_sym.code;
        s1_result.gram_count = count_wide[OUT_COUNT_BITS-1:0];
        s1_result.char_total = r_s1_chars;
        s1_result.word_total = r_s1_words;
    end

    // Output queue; admit a transaction only when its slot is guaranteed
    t_result    r_q [QUEUE_DEPTH];
    logic [1:0] r_wp, r_rp, r_cnt;
    logic       push, pop;

    assign push        = r_s1_vld;
    assign o_out_valid = (r_cnt != 2'd0);
    assign pop         = o_out_valid && i_out_ready;
    assign o_in_ready  = !r_clr.en
                         && (({1'b0, r_cnt} + {2'b00, r_s1_vld}) < 3'(QUEUE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= s1_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == LAST_SLOT) ? 2'd0 : r_wp + 2'd1;
            end
            if (pop) begin
                r_rp <= (r_rp == LAST_SLOT) ? 2'd0 : r_rp + 2'd1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    assign o_symbol_valid = r_q[r_rp].sym_vld;
    assign o_symbol_code  = r_q[r_rp].sym_code;
    assign o_gram_count   = r_q[r_rp].gram_count;
    assign o_char_total   = r_q[r_rp].char_total;
    assign o_word_total   = r_q[r_rp].word_total;

`ifndef SYNTHESIS
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr.en |-> !o_in_ready)
        else $error("transaction admitted during clearing pass");
    a_queue_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |-> (r_cnt != 2'(QUEUE_DEPTH)))
        else $error("output queue overflow");
    a_stage_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_s1_vld && push))
        else $error("accepted transaction did not reach the update stage");
    a_feed_zero_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && r_s1_mode == MODE_FEED) |-> (s1_result.gram_count == '0))
        else $error("feed transaction carries a count");
`endif

endmodule

>>> dv/tb_letter_ngram_histogram_unit.sv
// ----------------------------------------------------------------------------
// tb_letter_ngram_histogram_unit
// Self-checking bench for the letter n-gram histogram unit.
// ----------------------------------------------------------------------------
// A queue of text and read transactions, filled phase by phase, feeds a
// falling-edge driver. Every accepted transaction is folded into a local copy
// of the histogram tables and running totals. The expected result is queued,
// and each result taken on the output channel is compared field by field.
// Phases vary idling on both channels; one long receiver hold-off backs the
// unit up to its input, and the sender drains between phases.
// ----------------------------------------------------------------------------
module tb_letter_ngram_histogram_unit;

    import lnh_pkg::*;

    localparam int MAX_GRAM    = 3;
    localparam int COUNT_BITS  = 32;
    localparam int TOTAL_BITS  = 48;
    // the limit covers the clearing pass and many times the slowest run
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 150;
    localparam int TAIL_CYCLES = 20;
    localparam logic [LEN_BITS-1:0] LEN_NONE = 2'd0;

    typedef logic [BYTE_BITS-1:0] t_byte;
    typedef logic [LEN_BITS-1:0]  t_len;
    typedef logic [KEY_BITS-1:0]  t_key;
    typedef logic [SYM_BITS-1:0]  t_code;

    typedef struct packed {
        logic  mode;
        logic  start;
        t_byte text_byte;
        t_len  read_len;
        t_key  read_key;
    } t_text_item;

    // ------------------------------------------------------------------------
    // Clock, reset and block ports
    // ------------------------------------------------------------------------
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic  i_in_valid      = 1'b0;
    logic  i_mode          = MODE_FEED;
    logic  i_start_of_text = 1'b0;
    t_byte i_text_byte     = '0;
    t_len  i_read_length   = '0;
    t_key  i_read_key      = '0;
    logic  i_out_ready     = 1'b0;

    logic                      o_in_ready;
    logic                      o_out_valid;
    logic                      o_symbol_valid;
    logic [SYM_BITS-1:0]       o_symbol_code;
    logic [OUT_COUNT_BITS-1:0] o_gram_count;
    logic [OUT_TOTAL_BITS-1:0] o_char_total;
    logic [OUT_TOTAL_BITS-1:0] o_word_total;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    letter_ngram_histogram_unit #(
        .MAX_GRAM   (MAX_GRAM),
        .COUNT_BITS (COUNT_BITS),
        .TOTAL_BITS (TOTAL_BITS)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_mode          (i_mode),
        .i_start_of_text (i_start_of_text),
        .i_text_byte     (i_text_byte),
        .i_read_length   (i_read_length),
        .i_read_key      (i_read_key),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_symbol_valid  (o_symbol_valid),
        .o_symbol_code   (o_symbol_code),
        .o_gram_count    (o_gram_count),
        .o_char_total    (o_char_total),
        .o_word_total    (o_word_total)
    );

    // ------------------------------------------------------------------------
    // Shared bench state
    // ------------------------------------------------------------------------
    t_text_item text_stream[$];     // transactions waiting, newest at the front
    t_result    tally_results[$];   // results owed by the unit, newest at the front
    int         mismatch_count = 0;
    int         cycle_count    = 0;
    int         tx_idle_pct    = 0;
    int         rx_stall_pct   = 0;
    logic       byte_taken     = 1'b0;
    logic       rx_hold_req    = 1'b0;
    int         rx_hold_left   = 0;

    // Local copy of the histogram state
    logic [COUNT_BITS-1:0] hist_one   [32]    = '{default: '0};
    logic [COUNT_BITS-1:0] hist_two   [1024]  = '{default: '0};
    logic [COUNT_BITS-1:0] hist_three [32768] = '{default: '0};
    logic [KEY_BITS-1:0]   sym_hist   = '0;
    logic [1:0]            fill_pos   = '0;
    logic                  last_sep   = 1'b0;
    logic [TOTAL_BITS-1:0] chars_seen = '0;
    logic [TOTAL_BITS-1:0] words_seen = '0;

    // ------------------------------------------------------------------------
    // Histogram update for one accepted transaction; queue the result it owes
    // ------------------------------------------------------------------------
    task automatic tally_transaction(input t_text_item it);
        t_result r;
        logic    sym_ok;
        t_code   code;
        int      lim;
        r      = '0;
        sym_ok = 1'b0;
        code   = '0;
        lim    = (MAX_GRAM > 3) ? 3 : MAX_GRAM;
        if (it.mode == MODE_READ) begin
            // read only: start flag and byte play no part here
            case (it.read_len)
                LEN_ONE:   r.gram_count = OUT_COUNT_BITS'(hist_one[it.read_key[4:0]]);
                LEN_TWO:   r.gram_count = OUT_COUNT_BITS'(hist_two[it.read_key[9:0]]);
                LEN_THREE: r.gram_count = OUT_COUNT_BITS'(hist_three[it.read_key]);
                default:   r.gram_count = '0;
            endcase
        end else begin
            if (it.start) begin
                sym_hist = '0;
                fill_pos = '0;
                last_sep = 1'b0;
            end
            if (it.text_byte >= CHAR_UPPER_A && it.text_byte <= CHAR_UPPER_Z) begin
                sym_ok   = 1'b1;
                code     = t_code'(it.text_byte - CHAR_UPPER_A);
                last_sep = 1'b0;
            end else if (it.text_byte >= CHAR_LOWER_A && it.text_byte <= CHAR_LOWER_Z) begin
                sym_ok   = 1'b1;
                code     = t_code'(it.text_byte - CHAR_LOWER_A);
                last_sep = 1'b0;
            end else if (!last_sep) begin
                // only the first non-letter of a run becomes a separator
                sym_ok   = 1'b1;
                code     = SEP_SYMBOL;
                last_sep = 1'b1;
                if (words_seen != '1) words_seen = words_seen + 1'b1;
            end
            if (sym_ok) begin
                if (chars_seen != '1) chars_seen = chars_seen + 1'b1;
                sym_hist = {sym_hist[KEY_BITS-SYM_BITS-1:0], code};
                if (lim >= 1 && hist_one[sym_hist[4:0]] != '1)
                    hist_one[sym_hist[4:0]] = hist_one[sym_hist[4:0]] + 1'b1;
                if (lim >= 2 && fill_pos >= FILL_ONE && hist_two[sym_hist[9:0]] != '1)
                    hist_two[sym_hist[9:0]] = hist_two[sym_hist[9:0]] + 1'b1;
                if (lim >= 3 && fill_pos >= FILL_TWO && hist_three[sym_hist] != '1)
                    hist_three[sym_hist] = hist_three[sym_hist] + 1'b1;
                if (fill_pos != FILL_MAX) fill_pos = fill_pos + 1'b1;
            end
            r.sym_vld  = sym_ok;
            r.sym_code = code;
        end
        r.char_total = OUT_TOTAL_BITS'(chars_seen);
        r.word_total = OUT_TOTAL_BITS'(words_seen);
        tally_results.push_front(r);
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at cycle %0d: %s got 0x%0h want 0x%0h",
                 cycle_count, what, got, want);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic push_feed(input t_byte b, input logic start);
        t_text_item it;
        it.mode      = MODE_FEED;
        it.start     = start;
        it.text_byte = b;
        // length and key are ignored in feed mode: fill them with noise
        it.read_len  = t_len'($urandom_range(3));
        it.read_key  = t_key'($urandom_range(32767));
        text_stream.push_front(it);
    endtask

    task automatic push_read(input t_len len, input t_key key);
        t_text_item it;
        it.mode      = MODE_READ;
        it.start     = 1'($urandom_range(1));
        it.text_byte = t_byte'($urandom_range(255));
        it.read_len  = len;
        it.read_key  = key;
        text_stream.push_front(it);
    endtask

    // Lean on a few letters so that grams repeat and reads find counts
    function automatic t_byte pick_letter();
        t_byte idx;
        idx = ($urandom_range(99) < 70) ? t_byte'($urandom_range(4))
                                        : t_byte'($urandom_range(25));
        return ($urandom_range(1) != 0) ? CHAR_UPPER_A + idx : CHAR_LOWER_A + idx;
    endfunction

    function automatic t_byte pick_gap_byte();
        case ($urandom_range(3))
            0:       return t_byte'($urandom_range(8'h40, 8'h00));
            1:       return t_byte'($urandom_range(8'h60, 8'h5B));
            2:       return t_byte'($urandom_range(8'h7F, 8'h7B));
            default: return t_byte'($urandom_range(8'hFF, 8'h80));
        endcase
    endfunction

    function automatic t_key pick_read_key();
        t_key  k;
        t_code s;
        k = '0;
        if ($urandom_range(9) < 3) begin
            k = t_key'($urandom_range(32767));
        end else begin
            for (int n = 0; n < 3; n++) begin
                if ($urandom_range(99) < 80)  s = t_code'($urandom_range(4));
                else if ($urandom_range(1))   s = SEP_SYMBOL;
                else                          s = t_code'($urandom_range(25));
                k = {k[KEY_BITS-SYM_BITS-1:0], s};
            end
        end
        return k;
    endfunction

    // Mostly words separated by short non-letter runs, with reads and noise
    task automatic queue_text(input int count);
        int left;
        int roll;
        int wlen;
        int glen;
        left = count;
        while (left > 0) begin
            roll = $urandom_range(99);
            if (roll < 25) begin
                push_read(($urandom_range(9) == 0) ? LEN_NONE : t_len'($urandom_range(3, 1)),
                          pick_read_key());
                left--;
            end else if (roll < 32) begin
                push_feed(t_byte'($urandom_range(255)), 1'($urandom_range(1)));
                left--;
            end else begin
                wlen = $urandom_range(7, 1);
                glen = $urandom_range(3, 1);
                for (int n = 0; n < wlen; n++)
                    push_feed(pick_letter(), (n == 0) && ($urandom_range(29) == 0));
                for (int n = 0; n < glen; n++)
                    push_feed(pick_gap_byte(), 1'b0);
                left -= wlen + glen;
            end
        end
    endtask

    // Hold the sender until everything offered has come back
    task automatic drain_results();
        while (text_stream.size() != 0 || i_in_valid || tally_results.size() != 0)
            @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Driver: offer the next transaction once the current one is taken
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin : text_driver
        t_text_item it;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            byte_taken = 1'b0;
        end else if (!i_in_valid || byte_taken) begin
            byte_taken = 1'b0;
            if (text_stream.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                it = text_stream.pop_back();
                i_in_valid      <= 1'b1;
                i_mode          <= it.mode;
                i_start_of_text <= it.start;
                i_text_byte     <= it.text_byte;
                i_read_length   <= it.read_len;
                i_read_key      <= it.read_key;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, or a long hold-off counted here when requested
    always @(negedge i_clk) begin
        if (rx_hold_req) begin
            rx_hold_left = HOLD_CYCLES;
            rx_hold_req  = 1'b0;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: predict on input transactions, check output transactions
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : result_monitor
        t_text_item seen;
        t_result    want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("TEST FAILED");
            $finish;
        end else if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                seen.mode      = i_mode;
                seen.start     = i_start_of_text;
                seen.text_byte = i_text_byte;
                seen.read_len  = i_read_length;
                seen.read_key  = i_read_key;
                tally_transaction(seen);
                byte_taken = 1'b1;
            end
            if (o_out_valid && i_out_ready) begin
                if (tally_results.size() == 0) begin
                    report_mismatch("result with nothing owed", 64'(o_char_total), 64'd0);
                end else begin
                    want = tally_results.pop_back();
                    if (o_symbol_valid !== want.sym_vld)
                        report_mismatch("symbol_valid", 64'(o_symbol_valid), 64'(want.sym_vld));
                    if (o_symbol_code !== want.sym_code)
                        report_mismatch("symbol_code", 64'(o_symbol_code), 64'(want.sym_code));
                    if (o_gram_count !== want.gram_count)
                        report_mismatch("gram_count", 64'(o_gram_count), 64'(want.gram_count));
                    if (o_char_total !== want.char_total)
                        report_mismatch("char_total", 64'(o_char_total), 64'(want.char_total));
                    if (o_word_total !== want.word_total)
                        report_mismatch("word_total", 64'(o_word_total), 64'(want.word_total));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequence: reset, directed cases, then idling phases
    // ------------------------------------------------------------------------
    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: letter and non-letter boundaries, separator runs, start of
        // text, every read length and keys with unused high bits set
        push_feed(CHAR_UPPER_A, 1'b1);
        push_feed(CHAR_UPPER_Z, 1'b0);
        push_feed(CHAR_LOWER_A, 1'b0);
        push_feed(CHAR_LOWER_Z, 1'b0);
        push_feed(8'h40, 1'b0);            // first non-letter: separator
        push_feed(8'h5B, 1'b0);            // rest of the run: no symbol
        push_feed(8'h60, 1'b0);
        push_feed(8'h7B, 1'b0);
        push_feed(8'hFF, 1'b0);
        push_feed(CHAR_LOWER_A + 8'd1, 1'b0);
        push_feed(8'h00, 1'b0);
        push_feed(8'h80, 1'b0);
        push_feed(8'h7F, 1'b1);            // separator straight after start
        push_feed(CHAR_LOWER_A + 8'd2, 1'b0);
        push_feed(CHAR_LOWER_A, 1'b1);     // history cleared mid-text
        push_feed(CHAR_LOWER_A, 1'b0);
        push_feed(CHAR_UPPER_A, 1'b0);
        push_read(LEN_ONE, '0);
        push_read(LEN_TWO, '0);
        push_read(LEN_THREE, '0);
        push_read(LEN_NONE, '0);
        push_read(LEN_ONE, t_key'(SEP_SYMBOL));
        push_read(LEN_THREE, '1);
        push_read(LEN_ONE, 15'h7FE0);      // high bits ignored for one symbol
        push_read(LEN_TWO, t_key'({5'd25, SEP_SYMBOL}));
        drain_results();

        // No idling; hold the receiver off long enough to back up the input
        queue_text(450);
        repeat (20) @(posedge i_clk);
        rx_hold_req = 1'b1;
        drain_results();

        tx_idle_pct  = 57;
        rx_stall_pct = 0;
        queue_text(450);
        drain_results();

        tx_idle_pct  = 0;
        rx_stall_pct = 57;
        queue_text(450);
        drain_results();

        tx_idle_pct  = 6;
        rx_stall_pct = 6;
        queue_text(450);
        drain_results();

        // allow any stray result to show up before the verdict
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

>>> letter_ngram_histogram_unit.f
sv/lnh_pkg.sv
sv/lnh_front.sv
sv/lnh_count_table.sv
sv/letter_ngram_histogram_unit.sv
dv/tb_letter_ngram_histogram_unit.sv
